/* sv/assert_macros.svh */
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SXD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SXD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/sxd_pkg.sv */
// shared constants, codes and the sextet lookup of the segment decoder
`timescale 1ns / 1ps

package sxd_pkg;

  localparam int SXD_LINE_BYTES = 48;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 1'b1;

  localparam logic [23:0] SEGMENT_BYTES_RESET = 24'd0;
  localparam logic [15:0] CRC_POLY_RESET      = 16'h1021;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_CRC_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_LINE_LEN = 2'd1;
  localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd2;
  localparam logic [1:0] STATUS_BAD_CRC_LINE = 2'd3;

  // A-Z a-z 0-9 ( ) alphabet, anything else maps to zero
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] s;
    s = 6'd0;
    if (c inside {[8'h41:8'h5a]}) begin
      s = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7a]}) begin
      s = 6'(c - 8'h47);
    end else if (c inside {[8'h30:8'h39]}) begin
      s = 6'(c + 8'h04);
    end else if (c == 8'h28) begin
      s = 6'd62;
    end else if (c == 8'h29) begin
      s = 6'd63;
    end
    return s;
  endfunction

endpackage

/* sv/sxd_line_ram.sv */
// line buffer: one 24-bit word per character group, registered read
`timescale 1ns / 1ps

module sxd_line_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/sxd_crc_byte.sv */
// msb-first crc-16 update over one byte
`timescale 1ns / 1ps

module sxd_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [15:0] poly,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

/* sv/sextet_text_segment_decoder.sv */
// top level of the sextet text segment decoder
//
// Input channel (in_valid / in_stall): one text character per request with
// line_end on the last character of a line and segment_start on the first
// body character. Result channel (out_valid / out_stall): data bytes
// (kind 0) and one status per segment (kind 1); last marks the final
// result of the character that caused it.
// A character that ends no line is taken without a stall. A full body line
// stalls the input while its bytes are read back from the line buffer:
// a buffer read and then three bytes per four-character group, all
// through the single buffer read port. A line of the wrong length
// goes to the status state for its status; the crc line goes through a
// buffer read, then the compare in the status state.
// Results go out through a one-entry output register, so the next
// character is taken while the last result still waits. A stalled
// receiver holds the drain in place; nothing is dropped.
// Reset (rst_n low, synchronous) returns the registers to their defaults
// (segment_bytes 0, polynomial 0x1021) and the decoder to body phase.
// The buffer needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sextet_text_segment_decoder #(
  parameter int LINE_BYTES = sxd_pkg::SXD_LINE_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_code,
  input  logic                            in_line_end,
  input  logic                            in_segment_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_kind,
  output logic [7:0]                      out_data_byte,
  output logic [1:0]                      out_status,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [sxd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sxd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import sxd_pkg::*;

  localparam int LINE_GROUPS = LINE_BYTES / 3;
  localparam int LINE_CHARS  = LINE_GROUPS * 4;
  localparam int RELEASED    = LINE_GROUPS * 3;
  localparam int AW          = (LINE_GROUPS > 1) ? $clog2(LINE_GROUPS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_BYTE, S_CRC_RD, S_STATUS} state_t;
  typedef enum logic [1:0] {PH_BODY, PH_CRC, PH_DONE, PH_ERROR} phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [1:0]         gp_r, gp_nxt;
  logic [17:0]        held_r, held_nxt;
  logic [6:0]         lcc_r, lcc_nxt;
  logic [15:0]        crc_r, crc_nxt;
  logic signed [24:0] rem_r, rem_nxt;
  logic [23:0]        seg_bytes_r, seg_bytes_nxt;
  logic [15:0]        poly_r, poly_nxt;
  logic [AW-1:0]      word_idx_r, word_idx_nxt;
  logic [1:0]         byte_idx_r, byte_idx_nxt;
  logic               stat_cmp_r, stat_cmp_nxt;
  logic [1:0]         stat_code_r, stat_code_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  // values after an optional segment start
  phase_t             ph_eff;
  logic [1:0]         gp_eff;
  logic [17:0]        held_eff;
  logic [6:0]         lcc_eff;
  logic [15:0]        crc_eff;
  logic signed [24:0] rem_eff;

  logic [5:0]         sextet;
  logic [4:0]         grp;
  logic [6:0]         lcc_inc;
  logic signed [24:0] rem_dec;
  logic               out_free;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [23:0]        ram_wdata, ram_rdata;

  logic [7:0]         drain_byte;
  logic [15:0]        crc_calc;
  logic [15:0]        crc_stored;

  sxd_line_ram #(
    .DEPTH (LINE_GROUPS),
    .AW    (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sxd_crc_byte u_crc (
    .crc_in  (crc_r),
    .poly    (poly_r),
    .data    (drain_byte),
    .crc_out (crc_calc)
  );

  always_comb begin
    case (byte_idx_r)
      2'd0:    drain_byte = ram_rdata[23:16];
      2'd1:    drain_byte = ram_rdata[15:8];
      default: drain_byte = ram_rdata[7:0];
    endcase
  end

  // crc in the check line is stored low byte first
  assign crc_stored = {ram_rdata[15:8], ram_rdata[23:16]};

  always_comb begin
    if (in_segment_start) begin
      ph_eff   = (seg_bytes_r != 24'd0) ? PH_BODY : PH_CRC;
      gp_eff   = 2'd0;
      held_eff = 18'd0;
      lcc_eff  = 7'd0;
      crc_eff  = 16'd0;
      rem_eff  = signed'({1'b0, seg_bytes_r});
    end else begin
      ph_eff   = phase_r;
      gp_eff   = gp_r;
      held_eff = held_r;
      lcc_eff  = lcc_r;
      crc_eff  = crc_r;
      rem_eff  = rem_r;
    end
  end

  assign sextet   = sextet_of(in_char_code);
  assign grp      = lcc_eff[6:2];
  assign lcc_inc  = (lcc_eff == 7'd127) ? lcc_eff : lcc_eff + 7'd1;
  assign rem_dec  = rem_eff - 25'(RELEASED);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    gp_nxt         = gp_r;
    held_nxt       = held_r;
    lcc_nxt        = lcc_r;
    crc_nxt        = crc_r;
    rem_nxt        = rem_r;
    word_idx_nxt   = word_idx_r;
    byte_idx_nxt   = byte_idx_r;
    stat_cmp_nxt   = stat_cmp_r;
    stat_code_nxt  = stat_code_r;
    seg_bytes_nxt  = seg_bytes_r;
    poly_nxt       = poly_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    ram_we    = 1'b0;
    ram_waddr = grp[AW-1:0];
    ram_wdata = {sextet, held_eff};
    ram_re    = 1'b0;
    ram_raddr = word_idx_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENT_BYTES:  seg_bytes_nxt = cfg_wdata;
        CFG_CRC_POLYNOMIAL: poly_nxt      = cfg_wdata[15:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          phase_nxt = ph_eff;
          gp_nxt    = gp_eff;
          held_nxt  = held_eff;
          lcc_nxt   = lcc_eff;
          crc_nxt   = crc_eff;
          rem_nxt   = rem_eff;
          if (ph_eff == PH_BODY || ph_eff == PH_CRC) begin
            if (gp_eff == 2'd3) begin
              // group complete, groups past the line end are dropped
              ram_we   = (grp < 5'(LINE_GROUPS));
              held_nxt = 18'd0;
            end else begin
              case (gp_eff)
                2'd0:    held_nxt = held_eff | {12'd0, sextet};
                2'd1:    held_nxt = held_eff | {6'd0, sextet, 6'd0};
                default: held_nxt = held_eff | {sextet, 12'd0};
              endcase
            end
            gp_nxt  = gp_eff + 2'd1;
            lcc_nxt = lcc_inc;
            if (in_line_end) begin
              gp_nxt       = 2'd0;
              held_nxt     = 18'd0;
              lcc_nxt      = 7'd0;
              stat_cmp_nxt = 1'b0;
              if (ph_eff == PH_BODY) begin
                if (lcc_inc == 7'(LINE_CHARS)) begin
                  rem_nxt      = rem_dec;
                  phase_nxt    = (rem_dec <= 25'sd0) ? PH_CRC : PH_BODY;
                  word_idx_nxt = '0;
                  state_nxt    = S_RD;
                end else begin
                  stat_code_nxt = STATUS_BAD_LINE_LEN;
                  phase_nxt     = PH_ERROR;
                  state_nxt     = S_STATUS;
                end
              end else begin
                if (lcc_inc == 7'd4) begin
                  stat_cmp_nxt = 1'b1;
                  phase_nxt    = PH_DONE;
                  state_nxt    = S_CRC_RD;
                end else begin
                  stat_code_nxt = STATUS_BAD_CRC_LINE;
                  phase_nxt     = PH_ERROR;
                  state_nxt     = S_STATUS;
                end
              end
            end
          end
        end
      end
      S_RD: begin
        ram_re       = 1'b1;
        byte_idx_nxt = 2'd0;
        state_nxt    = S_BYTE;
      end
      S_BYTE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_DATA;
          out_data_nxt   = drain_byte;
          out_status_nxt = STATUS_CRC_OK;
          out_last_nxt   = 1'b0;
          crc_nxt        = crc_calc;
          if (byte_idx_r == 2'd2) begin
            if (word_idx_r == AW'(LINE_GROUPS - 1)) begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              word_idx_nxt = word_idx_r + AW'(1);
              state_nxt    = S_RD;
            end
          end else begin
            byte_idx_nxt = byte_idx_r + 2'd1;
          end
        end
      end
      S_CRC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_STATUS;
          out_data_nxt  = 8'd0;
          out_last_nxt  = 1'b1;
          if (stat_cmp_r) begin
            out_status_nxt = (crc_stored == crc_r) ? STATUS_CRC_OK : STATUS_CRC_MISMATCH;
          end else begin
            out_status_nxt = stat_code_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_BODY;
      gp_r        <= 2'd0;
      held_r      <= 18'd0;
      lcc_r       <= 7'd0;
      crc_r       <= 16'd0;
      rem_r       <= 25'sd0;
      seg_bytes_r <= SEGMENT_BYTES_RESET;
      poly_r      <= CRC_POLY_RESET;
      word_idx_r  <= '0;
      byte_idx_r  <= 2'd0;
      stat_cmp_r  <= 1'b0;
      stat_code_r <= STATUS_CRC_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      gp_r        <= gp_nxt;
      held_r      <= held_nxt;
      lcc_r       <= lcc_nxt;
      crc_r       <= crc_nxt;
      rem_r       <= rem_nxt;
      seg_bytes_r <= seg_bytes_nxt;
      poly_r      <= poly_nxt;
      word_idx_r  <= word_idx_nxt;
      byte_idx_r  <= byte_idx_nxt;
      stat_cmp_r  <= stat_cmp_nxt;
      stat_code_r <= stat_code_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r   <= out_kind_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data_byte = out_data_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  // buffer writes come only from accepted characters
  `SXD_ASSERT(a_write_when_idle, ram_we |-> (state_r == S_IDLE && in_valid), "buffer write outside idle")
  // every buffer read is followed by a byte or status emission state
  `SXD_ASSERT(a_read_then_use, ram_re |=> (state_r == S_BYTE || state_r == S_STATUS), "read data unused")
  // a status result always closes the results of its character
  `SXD_ASSERT(a_status_last, (out_valid && out_kind == KIND_STATUS) |-> out_last, "status without last")
  // no result is pending straight out of reset
  `SXD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule
